@@ src/bfs_pkg.sv @@
package bfs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_in;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] data_out;
		logic [7:0] front;
		logic [4:0] count;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic probe;
	} cell_ctrl_t;

endpackage

@@ src/bfs_cell.sv @@
module bfs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bfs_pkg::cell_ctrl_t ctrl,
	input  logic                load,
	input  logic [7:0]          din,
	input  logic [7:0]          nxt_data,
	input  logic                nxt_valid,
	output logic [7:0]          data,
	output logic                valid,
	output logic                hit
);
	import bfs_pkg::*;

	logic [7:0] data_q;
	logic       valid_q;
	logic       hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q  <= '0;
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				data_q  <= '0;
				valid_q <= 1'b0;
			end else if (ctrl.shift) begin
				data_q  <= nxt_data;
				valid_q <= nxt_valid;
			end else if (load) begin
				data_q  <= din;
				valid_q <= 1'b1;
			end
			if (ctrl.probe) begin
				hit_q <= valid_q && (data_q == din);
			end
		end
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule

@@ src/byte_fifo_with_search.sv @@
// Byte queue with membership search.
// Request channel: start with req (kind, data_in); a request is taken at
// every rising edge where start is high and busy is low. busy stays low,
// so one request can be issued in every cycle.
// Kinds: push, pop, search, clear. Each request gives one response on rsp,
// marked by done for exactly one cycle, once it has passed vld_s1 and done_q.
// The response carries ok, the popped byte, the front byte and the count
// after the operation. The receiver cannot stall; responses stream out in
// request order at one per cycle.
// Storage is a row of DEPTH cells, front in cell 0; a pop shifts every
// cell one place toward the front, a push loads the cell at the count,
// and a search registers a compare in each cell; the hits are ORed
// into rsp.ok when the response is registered.
// cfg_we/cfg_data write the capacity (values above DEPTH act as DEPTH);
// write it only while no response is pending.
// Reset (arst_n low) empties the queue, zeroes every cell and sets the
// capacity to 16.
module byte_fifo_with_search #(
	parameter int DEPTH = bfs_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bfs_pkg::req_t              req,
	output logic                       done,
	output bfs_pkg::rsp_t              rsp,
	input  logic                       cfg_we,
	input  logic [bfs_pkg::CAP_W-1:0]  cfg_data
);
	import bfs_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [LW-1:0]    lim;
	logic             accept;
	logic             push_ok;
	logic             pop_ok;
	cell_ctrl_t       ctrl;
	logic [DEPTH-1:0] load_sel;
	logic [7:0]       cdata [DEPTH];
	logic [DEPTH-1:0] cvalid;
	logic [DEPTH-1:0] chit;

	logic             vld_s1;
	logic             srch_s1;
	logic             ok_s1;
	logic [7:0]       dout_s1;
	logic             done_q;
	rsp_t             rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		if (LW'(cap_q) > LW'(DEPTH)) begin
			lim = LW'(DEPTH);
		end else begin
			lim = LW'(cap_q);
		end
	end

	assign push_ok = LW'(count_q) < lim;
	assign pop_ok  = count_q != '0;

	assign ctrl.clear = accept && (req.kind == OP_CLEAR);
	assign ctrl.shift = accept && (req.kind == OP_POP) && pop_ok;
	assign ctrl.probe = accept && (req.kind == OP_SEARCH);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [7:0] nd;
		logic       nv;
		if (i == DEPTH - 1) begin : g_last
			assign nd = '0;
			assign nv = 1'b0;
		end else begin : g_mid
			assign nd = cdata[i+1];
			assign nv = cvalid[i+1];
		end
		assign load_sel[i] = accept && (req.kind == OP_PUSH) && push_ok
			&& (count_q == CW'(i));
		bfs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.load      (load_sel[i]),
			.din       (req.data_in),
			.nxt_data  (nd),
			.nxt_valid (nv),
			.data      (cdata[i]),
			.valid     (cvalid[i]),
			.hit       (chit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			vld_s1 <= accept;
			done_q <= vld_s1;
			if (accept) begin
				unique case (op_t'(req.kind))
					OP_PUSH: begin
						if (push_ok) begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_POP: begin
						if (pop_ok) begin
							count_q <= count_q - CW'(1);
						end
					end
					OP_SEARCH: ;
					OP_CLEAR: count_q <= '0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			srch_s1 <= req.kind == OP_SEARCH;
			unique case (op_t'(req.kind))
				OP_PUSH: begin
					ok_s1   <= push_ok;
					dout_s1 <= '0;
				end
				OP_POP: begin
					ok_s1   <= pop_ok;
					dout_s1 <= cdata[0];
				end
				OP_SEARCH: begin
					ok_s1   <= 1'b0;
					dout_s1 <= '0;
				end
				OP_CLEAR: begin
					ok_s1   <= 1'b1;
					dout_s1 <= '0;
				end
				default: begin
					ok_s1   <= 1'b0;
					dout_s1 <= '0;
				end
			endcase
		end
		if (vld_s1) begin
			rsp_q.ok       <= srch_s1 ? (|chit) : ok_s1;
			rsp_q.data_out <= dout_s1;
			rsp_q.front    <= cdata[0];
			rsp_q.count    <= CAP_W'(count_q);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count above depth");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cvalid[0] == (count_q != '0))
		else $error("front cell validity disagrees with count");

	a_resp_timing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("response missing two cycles after request");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!cvalid[0] |-> cdata[0] == '0)
		else $error("empty front cell not zero");

endmodule
